### design/ooct_pkg.sv
// ----------------------------------------------------------------------------
// ooct_pkg
// Shared command codes and cell control type for the completion tracker.
// ----------------------------------------------------------------------------
package ooct_pkg;

    // Request command codes
    localparam logic [1:0] CMD_ONE_DONE = 2'd0;
    localparam logic [1:0] CMD_ALL_DONE = 2'd1;
    localparam logic [1:0] CMD_RESET    = 2'd2;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // Control broadcast to every window cell
    typedef struct packed {
        logic shift;   // take the neighbor's bit
        logic clear;   // drop the bit
    } t_cell_ctl;

endpackage

### design/ooct_cell.sv
// ----------------------------------------------------------------------------
// ooct_cell
// One slot of the stray window: holds a single completion bit.
// ----------------------------------------------------------------------------
module ooct_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ooct_pkg::t_cell_ctl i_ctl,
    input  logic               i_set,
    input  logic               i_next_bit,
    output logic               o_bit
);
    import ooct_pkg::*;

    logic r_bit;
    logic n_bit;

    // Clear wins, then shift from the neighbor, then mark
    always_comb begin
        n_bit = r_bit;
        if (i_ctl.clear) begin
            n_bit = 1'b0;
        end else if (i_ctl.shift) begin
            n_bit = i_next_bit;
        end else if (i_set) begin
            n_bit = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

### design/ooct_window.sv
// ----------------------------------------------------------------------------
// ooct_window
// Row of window cells; slot i stands for index head + i. A shift moves
// every bit one slot toward the head.
// ----------------------------------------------------------------------------
module ooct_window #(
    parameter int WINDOW_SLOTS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ooct_pkg::t_cell_ctl               i_ctl,
    input  logic                              i_set_en,
    input  logic [$clog2(WINDOW_SLOTS)-1:0]   i_set_slot,
    output logic                              o_head_bit
);
    import ooct_pkg::*;

    localparam int SLOT_BITS = $clog2(WINDOW_SLOTS);

    logic [WINDOW_SLOTS:0] w_bits;

    // Nothing shifts in past the far end
    assign w_bits[WINDOW_SLOTS] = 1'b0;

    for (genvar g = 0; g < WINDOW_SLOTS; g++) begin : g_cell
        logic w_set;
        assign w_set = i_set_en && (i_set_slot == SLOT_BITS'(g));

        ooct_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_set      (w_set),
            .i_next_bit (w_bits[g+1]),
            .o_bit      (w_bits[g])
        );
    end

    assign o_head_bit = w_bits[0];

endmodule

### design/out_of_order_completion_tracker.sv
// ----------------------------------------------------------------------------
// out_of_order_completion_tracker
// Keeps the contiguous completed count of a job whose segments finish out of
// order, with a shifting bitmap of strays that finished past the head.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  request  | in        | i_in_valid/o_in_ready  | i_cmd, i_segment_index
//  result   | out       | o_out_valid/i_out_ready| o_completed_count, o_all_done,
//           |           |                        | o_job_finished_now,
//           |           |                        | o_index_rejected
//  config   | in        | i_cfg_wr_en            | i_cfg_wr_data (total segments)
//
//  A request passes through the accept, execute and result-load steps before
//  the next accept; one that completes the head segment also walks the head
//  over the marked strays that follow it, one window slot per cycle, before
//  its result load.
//  One request is in flight at a time; the next is taken while a result
//  still waits in the output register. A stalled output holds the sequencer
//  in its result-load step. Synchronous reset clears the count, the total
//  and every window cell at once.
// ----------------------------------------------------------------------------
module out_of_order_completion_tracker #(
    parameter int WINDOW_SLOTS = 64,
    parameter int COUNT_BITS   = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [COUNT_BITS-1:0] i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_cmd,
    input  logic [COUNT_BITS-1:0] i_segment_index,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COUNT_BITS-1:0] o_completed_count,
    output logic                  o_all_done,
    output logic                  o_job_finished_now,
    output logic                  o_index_rejected
);
    import ooct_pkg::*;

    localparam int SLOT_BITS = $clog2(WINDOW_SLOTS);
    localparam int CMP_BITS  = (COUNT_BITS > 11) ? COUNT_BITS + 1 : 12;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_cmd;
    logic                  r_rej;
    logic                  r_hit;
    logic [SLOT_BITS-1:0]  r_slot;
    logic [COUNT_BITS-1:0] r_head, n_head;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_fin, n_fin;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  r_out_all;
    logic                  r_out_fin;
    logic                  r_out_rej;

    logic                  w_accept;
    logic                  w_load;
    logic [COUNT_BITS-1:0] w_diff;
    logic                  w_reject;
    logic                  w_head_bit;
    logic                  w_set_en;
    t_cell_ctl             w_ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Classify the index against head, total and window at accept time
    assign w_diff   = i_segment_index - r_head;
    assign w_reject = (i_segment_index < r_head) || (i_segment_index >= r_total) ||
                      (CMP_BITS'(w_diff) >= CMP_BITS'(WINDOW_SLOTS));

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_rej  <= w_reject;
            r_hit  <= (i_segment_index == r_head);
            r_slot <= w_diff[SLOT_BITS-1:0];
        end
    end

    // Hold the total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cfg_wr_en) begin
            r_total <= i_cfg_wr_data;
        end
    end

    // Sequencer: execute the command, walk the head over strays, load result
    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_fin      = r_fin;
        w_ctl      = '0;
        w_set_en   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                    n_fin   = 1'b0;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_cmd)
                    CMD_ONE_DONE: begin
                        if (!r_rej) begin
                            if (r_hit) begin
                                n_head      = r_head + 1'b1;
                                w_ctl.shift = 1'b1;
                                n_state     = ST_WALK;
                            end else begin
                                w_set_en = 1'b1;
                            end
                        end
                    end
                    CMD_ALL_DONE: begin
                        n_head      = r_total;
                        w_ctl.clear = 1'b1;
                        n_fin       = 1'b1;
                    end
                    CMD_RESET: begin
                        n_head      = '0;
                        w_ctl.clear = 1'b1;
                    end
                    CMD_UNUSED: begin
                        n_head = r_head;
                    end
                    default: begin
                        n_head = r_head;
                    end
                endcase
            end
            ST_WALK: begin
                if (w_head_bit) begin
                    n_head      = r_head + 1'b1;
                    w_ctl.shift = 1'b1;
                end else begin
                    n_fin   = (r_head == r_total);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_fin   <= n_fin;
        end
    end

    ooct_window #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_set_en   (w_set_en),
        .i_set_slot (r_slot),
        .o_head_bit (w_head_bit)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_count <= r_head;
            r_out_all   <= (r_head == r_total);
            r_out_fin   <= r_fin;
            r_out_rej   <= (r_cmd == CMD_ONE_DONE) && r_rej;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_completed_count  = r_out_count;
    assign o_all_done         = r_out_all;
    assign o_job_finished_now = r_out_fin;
    assign o_index_rejected   = r_out_rej;

    // Slot zero stays clear outside the head walk
    a_slot0_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_DONE) |-> !w_head_bit)
        else $error("window slot zero set outside head walk");

    // An accepted request always goes to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    // A new result only follows the result-load step
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result appeared without load step");

    // A dropped index never finishes the job
    a_rej_no_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rej) |-> !r_out_fin)
        else $error("rejected request reported job completion");

endmodule

### tb/sv/tb_out_of_order_completion_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_out_of_order_completion_tracker
// Drives completion requests into the tracker from directed cases and from
// locally shuffled random jobs, with random gaps on the request side and
// random stalls on the result side. A behavioral predictor tracks the head
// count and the stray window; every result is checked against it in order.
// ----------------------------------------------------------------------------
module tb_out_of_order_completion_tracker;
    import ooct_pkg::*;

    localparam int WINDOW_SLOTS = 64;
    localparam int COUNT_BITS   = 24;
    localparam int SLOT_BITS    = $clog2(WINDOW_SLOTS);
    localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};
    localparam int RANDOM_ITEMS = 1950;
    localparam int CALM_ITEMS   = 300;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  all_done;
        logic                  finished_now;
        logic                  rejected;
    } t_tracker_status;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [COUNT_BITS-1:0] i_cfg_wr_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_cmd;
    logic [COUNT_BITS-1:0] i_segment_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [COUNT_BITS-1:0] o_completed_count;
    logic                  o_all_done;
    logic                  o_job_finished_now;
    logic                  o_index_rejected;

    // predictor state
    logic [COUNT_BITS-1:0]   head_pred;
    logic [WINDOW_SLOTS-1:0] strays_pred;
    logic [COUNT_BITS-1:0]   total_pred;

    t_tracker_status expected_status_q[$];
    t_tracker_status status_want;
    int              mismatch_count;
    int              requests_sent;
    bit              idle_on;
    logic [COUNT_BITS-1:0] last_index;

    out_of_order_completion_tracker #(
        .WINDOW_SLOTS(WINDOW_SLOTS),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_segment_index   (i_segment_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_completed_count (o_completed_count),
        .o_all_done        (o_all_done),
        .o_job_finished_now(o_job_finished_now),
        .o_index_rejected  (o_index_rejected)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("out_of_order_completion_tracker regression: fail");
        $finish;
    end

    // Advance the predicted head and window by one request
    function automatic t_tracker_status advance_tracker(input logic [1:0] cmd,
                                                        input logic [COUNT_BITS-1:0] idx);
        t_tracker_status st;
        st = '0;
        case (cmd)
            CMD_ONE_DONE: begin
                if (idx < head_pred || idx >= total_pred ||
                    (idx - head_pred) >= WINDOW_SLOTS) begin
                    st.rejected = 1'b1;
                end else if (idx == head_pred) begin
                    head_pred   = head_pred + 1'b1;
                    strays_pred = strays_pred >> 1;
                    while (strays_pred[0]) begin
                        head_pred   = head_pred + 1'b1;
                        strays_pred = strays_pred >> 1;
                    end
                    st.finished_now = (head_pred == total_pred);
                end else begin
                    strays_pred[SLOT_BITS'(idx - head_pred)] = 1'b1;
                end
            end
            CMD_ALL_DONE: begin
                head_pred       = total_pred;
                strays_pred     = '0;
                st.finished_now = 1'b1;
            end
            CMD_RESET: begin
                head_pred   = '0;
                strays_pred = '0;
            end
            default: ;
        endcase
        st.count    = head_pred;
        st.all_done = (head_pred == total_pred);
        return st;
    endfunction

    // Send one request, with an optional gap before it
    task automatic send_request(input logic [1:0] cmd, input logic [COUNT_BITS-1:0] idx);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_segment_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        expected_status_q.push_back(advance_tracker(cmd, idx));
        requests_sent++;
        last_index = idx;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the segment total while the block is idle
    task automatic write_total(input logic [COUNT_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        total_pred = value;
    endtask

    // Result side: random stall bursts while idling is on
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected none actual count %0d",
                         $time, o_completed_count);
            end else begin
                status_want = expected_status_q.pop_front();
                check_field("completed_count", status_want.count, o_completed_count);
                check_field("all_done", status_want.all_done, o_all_done);
                check_field("job_finished_now", status_want.finished_now,
                            o_job_finished_now);
                check_field("index_rejected", status_want.rejected, o_index_rejected);
            end
        end
    end

    // Zero total: every index dropped, job reads complete
    task automatic test_empty_job();
        write_total('0);
        send_request(CMD_ONE_DONE, '0);
        send_request(CMD_ONE_DONE, MAX_COUNT);
        send_request(CMD_ALL_DONE, '0);
        send_request(CMD_UNUSED, 24'h5A5A5A);
        wait_idle();
    endtask

    // Window edges, repeats, behind-head and past-total drops at max total
    task automatic test_window_edges();
        write_total(MAX_COUNT);
        send_request(CMD_RESET, '0);
        send_request(CMD_ONE_DONE, COUNT_BITS'(WINDOW_SLOTS - 1));
        send_request(CMD_ONE_DONE, COUNT_BITS'(WINDOW_SLOTS));
        send_request(CMD_ONE_DONE, COUNT_BITS'(WINDOW_SLOTS - 1));
        send_request(CMD_ONE_DONE, COUNT_BITS'(2));
        send_request(CMD_ONE_DONE, COUNT_BITS'(1));
        send_request(CMD_ONE_DONE, '0);
        send_request(CMD_ONE_DONE, '0);
        send_request(CMD_ONE_DONE, MAX_COUNT);
        send_request(CMD_ONE_DONE, COUNT_BITS'(WINDOW_SLOTS + 2));
        send_request(CMD_ALL_DONE, '0);
        send_request(CMD_ONE_DONE, MAX_COUNT - 1'b1);
        wait_idle();
    endtask

    // Small job finishing in reverse, then total lowered below the head
    task automatic test_finish_and_lowered_total();
        write_total(COUNT_BITS'(3));
        send_request(CMD_RESET, '0);
        send_request(CMD_ONE_DONE, COUNT_BITS'(2));
        send_request(CMD_ONE_DONE, COUNT_BITS'(1));
        send_request(CMD_ONE_DONE, '0);
        send_request(CMD_RESET, '0);
        send_request(CMD_ONE_DONE, '0);
        send_request(CMD_ONE_DONE, COUNT_BITS'(1));
        wait_idle();
        write_total(COUNT_BITS'(1));
        send_request(CMD_ONE_DONE, COUNT_BITS'(2));
        send_request(CMD_ALL_DONE, '0);
        wait_idle();
    endtask

    // Random jobs: locally shuffled segment orders with noise mixed in
    task automatic test_random_jobs();
        int order[$];
        int n;
        int j;
        int tmp;
        int pick;
        logic [COUNT_BITS-1:0] new_total;
        requests_sent = 0;
        while (requests_sent < RANDOM_ITEMS) begin
            idle_on = (requests_sent < RANDOM_ITEMS - CALM_ITEMS) &&
                      ($urandom_range(0, 3) != 0);
            // pick the total for this job
            pick = $urandom_range(0, 19);
            if (pick == 0)
                new_total = '0;
            else if (pick == 1)
                new_total = MAX_COUNT;
            else if (pick == 2)
                new_total = COUNT_BITS'($urandom_range(0, MAX_COUNT));
            else if (pick == 3 && head_pred != 0)
                new_total = COUNT_BITS'($urandom_range(0, head_pred - 1));
            else if (pick < 8)
                new_total = COUNT_BITS'($urandom_range(41, 120));
            else
                new_total = COUNT_BITS'($urandom_range(1, 40));
            write_total(new_total);
            if (pick != 3 || $urandom_range(0, 1) == 0)
                send_request(CMD_RESET, COUNT_BITS'($urandom_range(0, MAX_COUNT)));
            // build a locally shuffled segment order
            n = (new_total > 90) ? 90 : int'(new_total);
            order.delete();
            for (int i = 0; i < n; i++) order.push_back(i);
            for (int k = 0; k < n; k++) begin
                j = k + $urandom_range(0, (n - 1 - k < 9) ? n - 1 - k : 9);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            // send the segments, with occasional noise requests
            foreach (order[k]) begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    send_request(CMD_ONE_DONE, COUNT_BITS'($urandom_range(0, MAX_COUNT)));
                else if (pick == 1)
                    send_request(CMD_ONE_DONE, last_index);
                else if (pick == 2)
                    send_request(CMD_UNUSED, COUNT_BITS'($urandom_range(0, MAX_COUNT)));
                else if (pick == 3)
                    send_request(CMD_ONE_DONE, COUNT_BITS'(head_pred + WINDOW_SLOTS - 1 +
                                 $urandom_range(0, 1)));
                else if (pick == 4 && $urandom_range(0, 7) == 0)
                    send_request(CMD_RESET, COUNT_BITS'($urandom_range(0, MAX_COUNT)));
                send_request(CMD_ONE_DONE, COUNT_BITS'(order[k]));
            end
            if (head_pred != total_pred || $urandom_range(0, 3) == 0)
                send_request(CMD_ALL_DONE, COUNT_BITS'($urandom_range(0, MAX_COUNT)));
            wait_idle();
        end
        idle_on = 1'b0;
    endtask

    // Main sequence
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_ONE_DONE;
        i_segment_index = '0;
        head_pred       = '0;
        strays_pred     = '0;
        total_pred      = '0;
        mismatch_count  = 0;
        requests_sent   = 0;
        last_index      = '0;
        idle_on         = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_job();
        test_window_edges();
        test_finish_and_lowered_total();
        test_random_jobs();

        wait_idle();
        if (mismatch_count == 0 && expected_status_q.size() == 0) begin
            $display("out_of_order_completion_tracker regression: pass");
        end else begin
            $display("out_of_order_completion_tracker regression: fail");
        end
        $finish;
    end

endmodule

### out_of_order_completion_tracker.f
design/ooct_pkg.sv
design/ooct_cell.sv
design/ooct_window.sv
design/out_of_order_completion_tracker.sv
tb/sv/tb_out_of_order_completion_tracker.sv
